### design/ssbf_pkg.sv
// Shared types and constants for the spectral significant bin finder.
// No dependencies; used by every module of the block.
package ssbf_pkg;

  localparam int DATA_W  = 24;            // bin component / multiplier operand width
  localparam int RATIO_W = 24;            // ratio register, unsigned Q16.8
  localparam int MAG_W   = 2 * DATA_W;    // squared magnitude / multiplier product
  localparam int ACC_W   = 2 * MAG_W;     // mag2 * ratio^2
  localparam int IDX_W   = 12;            // reported bin index width
  localparam int MAX_BINS_DEF = 4096;

  localparam logic [RATIO_W-1:0] RATIO_DEF = RATIO_W'(25600);  // 100.0

  // multiplier operand pairs
  typedef enum logic [2:0] {
    SEL_RR = 3'd0,   // ratio * ratio
    SEL_RE = 3'd1,   // |re| * |re|
    SEL_IM = 3'd2,   // |im| * |im|
    SEL_LL = 3'd3,   // mag lo * rr lo
    SEL_LH = 3'd4,   // mag lo * rr hi
    SEL_HL = 3'd5,   // mag hi * rr lo
    SEL_HH = 3'd6    // mag hi * rr hi
  } mul_sel_t;

  // alignment of a partial product into the accumulator
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_24 = 2'd1,
    SH_48 = 2'd2
  } shift_sel_t;

  typedef struct packed {
    mul_sel_t   mul_sel;
    logic       rr_load;    // rr <= product
    logic       mag_load;   // mag <= product
    logic       mag_add;    // mag <= mag + product
    logic       peak_upd;   // running peak update from mag
    logic       acc_en;
    logic       acc_clr;    // start a fresh sum
    shift_sel_t acc_sh;
    logic       finish;     // significance test, counter step, result
  } ctrl_t;

endpackage

### design/ssbf_mul.sv
// Shared 24 x 24 unsigned multiplier with registered product.
// Depends on ssbf_pkg for operand widths.
module ssbf_mul (
  input  logic                        clk,
  input  logic [ssbf_pkg::DATA_W-1:0] op_a,
  input  logic [ssbf_pkg::DATA_W-1:0] op_b,
  output logic [ssbf_pkg::MAG_W-1:0]  prod
);

  logic [ssbf_pkg::MAG_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ssbf_pkg::MAG_W'(op_a) * ssbf_pkg::MAG_W'(op_b);
  end

  assign prod = prod_r;

endmodule

### design/ssbf_ctrl.sv
// Sequencer for one bin: schedules the shared multiplier, adders and the
// final significance test. Depends on ssbf_pkg (ctrl_t and select codes).
module ssbf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,      // word accepted this cycle
  input  logic                  out_block,  // result slot still occupied
  output logic                  idle,
  output ssbf_pkg::ctrl_t       ctrl
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RR   = 11'b000_0000_0010,
    S_RE   = 11'b000_0000_0100,
    S_IM   = 11'b000_0000_1000,
    S_MAG  = 11'b000_0001_0000,
    S_P0   = 11'b000_0010_0000,
    S_P1   = 11'b000_0100_0000,
    S_P2   = 11'b000_1000_0000,
    S_P3   = 11'b001_0000_0000,
    S_P4   = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // product of the operands issued in one state shows up in the next one
  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    ctrl.mul_sel = ssbf_pkg::SEL_RR;
    ctrl.acc_sh  = ssbf_pkg::SH_0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_RR;
      end
      S_RR: begin
        ctrl.mul_sel = ssbf_pkg::SEL_RR;
        state_nxt = S_RE;
      end
      S_RE: begin
        ctrl.mul_sel = ssbf_pkg::SEL_RE;
        ctrl.rr_load = 1'b1;
        state_nxt = S_IM;
      end
      S_IM: begin
        ctrl.mul_sel  = ssbf_pkg::SEL_IM;
        ctrl.mag_load = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        ctrl.mag_add = 1'b1;
        state_nxt = S_P0;
      end
      S_P0: begin
        ctrl.peak_upd = 1'b1;
        ctrl.mul_sel  = ssbf_pkg::SEL_LL;
        state_nxt = S_P1;
      end
      S_P1: begin
        ctrl.mul_sel = ssbf_pkg::SEL_LH;
        ctrl.acc_en  = 1'b1;
        ctrl.acc_clr = 1'b1;
        ctrl.acc_sh  = ssbf_pkg::SH_0;
        state_nxt = S_P2;
      end
      S_P2: begin
        ctrl.mul_sel = ssbf_pkg::SEL_HL;
        ctrl.acc_en  = 1'b1;
        ctrl.acc_sh  = ssbf_pkg::SH_24;
        state_nxt = S_P3;
      end
      S_P3: begin
        ctrl.mul_sel = ssbf_pkg::SEL_HH;
        ctrl.acc_en  = 1'b1;
        ctrl.acc_sh  = ssbf_pkg::SH_24;
        state_nxt = S_P4;
      end
      S_P4: begin
        ctrl.acc_en = 1'b1;
        ctrl.acc_sh = ssbf_pkg::SH_48;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_block) begin
          ctrl.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle = (state_r == S_IDLE);

endmodule

### design/spectral_significant_bin_finder.sv
// Top level of the spectral significant bin finder: datapath registers around
// the shared multiplier (ssbf_mul) and the sequencer (ssbf_ctrl); uses ssbf_pkg.
//
// One FFT bin (re, im) per input word. The block tracks the running peak of
// re^2 + im^2, the first bin reaching it, and the latest bin whose squared
// magnitude times ratio^2 exceeds the running peak (bin included) scaled by
// 2^16. On a word with last_bin set it emits both indices and starts a new
// frame. A new word is taken only once the previous bin is done, since all
// seven 24x24 products (ratio^2, re^2, im^2, four partials of the 48x48 test
// product) go one after another through the single multiplier.
// The final bin of a frame also waits while a previous result is still held
// by out_stall. The ratio port is always ready; a zero ratio means 100.0.
module spectral_significant_bin_finder #(
  parameter int MAX_BINS = ssbf_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ssbf_pkg::DATA_W-1:0]  in_real_part,
  input  logic signed [ssbf_pkg::DATA_W-1:0]  in_imag_part,
  input  logic                                in_last_bin,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ssbf_pkg::IDX_W-1:0]          out_strongest_bin,
  output logic [ssbf_pkg::IDX_W-1:0]          out_significant_bin,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssbf_pkg::RATIO_W-1:0]        cfg_ratio
);

  localparam int CNT_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int DW    = ssbf_pkg::DATA_W;
  localparam int MW    = ssbf_pkg::MAG_W;
  localparam int AW    = ssbf_pkg::ACC_W;
  localparam int IW    = ssbf_pkg::IDX_W;

  ssbf_pkg::ctrl_t ctrl;
  logic            idle;
  logic            accept;
  logic            out_block;

  logic [ssbf_pkg::RATIO_W-1:0] ratio_r;
  logic [ssbf_pkg::RATIO_W-1:0] ratio_eff;

  logic [DW-1:0] re_abs_r, im_abs_r;
  logic          last_r;
  logic [DW-1:0] re_abs, im_abs;

  logic [DW-1:0] op_a, op_b;
  logic [MW-1:0] prod;
  logic [MW-1:0] rr_r, mag_r;
  logic [AW-1:0] acc_r, acc_nxt, pp_aligned;

  logic [MW-1:0]    peak_r;
  logic [IW-1:0]    peak_idx_r, signif_idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IW-1:0]    cnt_idx;
  logic             sig_hit;

  logic          out_valid_r;
  logic [IW-1:0] out_strong_r, out_signif_r;

  assign accept    = in_valid && idle;
  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;
  assign out_block = last_r && out_valid_r && out_stall;

  // -- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= ssbf_pkg::RATIO_DEF;
    end else if (cfg_valid) begin
      ratio_r <= cfg_ratio;
    end
  end

  assign ratio_eff = (ratio_r == '0) ? ssbf_pkg::RATIO_DEF : ratio_r;

  // -- input capture; |-2^23| = 2^23 still fits unsigned 24 bits
  assign re_abs = in_real_part[DW-1] ? (~in_real_part + DW'(1)) : in_real_part;
  assign im_abs = in_imag_part[DW-1] ? (~in_imag_part + DW'(1)) : in_imag_part;

  always_ff @(posedge clk) begin
    if (accept) begin
      re_abs_r <= re_abs;
      im_abs_r <= im_abs;
      last_r   <= in_last_bin;
    end
  end

  // -- shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      ssbf_pkg::SEL_RR: begin op_a = ratio_eff;        op_b = ratio_eff;        end
      ssbf_pkg::SEL_RE: begin op_a = re_abs_r;         op_b = re_abs_r;         end
      ssbf_pkg::SEL_IM: begin op_a = im_abs_r;         op_b = im_abs_r;         end
      ssbf_pkg::SEL_LL: begin op_a = mag_r[DW-1:0];    op_b = rr_r[DW-1:0];     end
      ssbf_pkg::SEL_LH: begin op_a = mag_r[DW-1:0];    op_b = rr_r[MW-1:DW];    end
      ssbf_pkg::SEL_HL: begin op_a = mag_r[MW-1:DW];   op_b = rr_r[DW-1:0];     end
      ssbf_pkg::SEL_HH: begin op_a = mag_r[MW-1:DW];   op_b = rr_r[MW-1:DW];    end
      default:          begin op_a = '0;               op_b = '0;               end
    endcase
  end

  ssbf_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  ssbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .out_block (out_block),
    .idle      (idle),
    .ctrl      (ctrl)
  );

  // -- squared magnitude, ratio^2 and the 96-bit test product
  always_comb begin
    case (ctrl.acc_sh)
      ssbf_pkg::SH_0:  pp_aligned = {{(AW-MW){1'b0}}, prod};
      ssbf_pkg::SH_24: pp_aligned = {{(AW-MW-DW){1'b0}}, prod, {DW{1'b0}}};
      ssbf_pkg::SH_48: pp_aligned = {prod, {(AW-MW){1'b0}}};
      default:         pp_aligned = '0;
    endcase
    acc_nxt = (ctrl.acc_clr ? '0 : acc_r) + pp_aligned;
  end

  always_ff @(posedge clk) begin
    if (ctrl.rr_load) rr_r <= prod;
    if (ctrl.mag_load) begin
      mag_r <= prod;
    end else if (ctrl.mag_add) begin
      mag_r <= mag_r + prod;   // re^2 + im^2 < 2^48
    end
    if (ctrl.acc_en) acc_r <= acc_nxt;
  end

  // -- frame state
  generate
    if (CNT_W >= IW) begin : g_idx_trunc
      assign cnt_idx = cnt_r[IW-1:0];
    end else begin : g_idx_ext
      assign cnt_idx = {{(IW-CNT_W){1'b0}}, cnt_r};
    end
  endgenerate

  // mag2 * r^2 > peak << 16, peak already includes this bin
  assign sig_hit = acc_r > {{(AW-MW-16){1'b0}}, peak_r, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r       <= '0;
      peak_idx_r   <= '0;
      signif_idx_r <= '0;
      cnt_r        <= '0;
    end else if (ctrl.peak_upd) begin
      if (mag_r > peak_r) begin
        peak_r     <= mag_r;
        peak_idx_r <= cnt_idx;
      end
    end else if (ctrl.finish) begin
      if (last_r) begin
        peak_r       <= '0;
        peak_idx_r   <= '0;
        signif_idx_r <= '0;
        cnt_r        <= '0;
      end else begin
        if (sig_hit) signif_idx_r <= cnt_idx;
        if (cnt_r == CNT_W'(MAX_BINS - 1)) begin
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // -- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish && last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish && last_r) begin
      out_strong_r <= peak_idx_r;
      out_signif_r <= sig_hit ? cnt_idx : signif_idx_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_strongest_bin   = out_strong_r;
  assign out_significant_bin = out_signif_r;

endmodule

### test/tb_spectral_significant_bin_finder.sv
// Testbench for spectral_significant_bin_finder: streams FFT bins, predicts the
// strongest and significant bin of every frame and checks each result word.
// Depends on ssbf_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_spectral_significant_bin_finder;

  localparam int DATA_W  = ssbf_pkg::DATA_W;
  localparam int RATIO_W = ssbf_pkg::RATIO_W;
  localparam int MAG_W   = ssbf_pkg::MAG_W;
  localparam int IDX_W   = ssbf_pkg::IDX_W;
  localparam logic [RATIO_W-1:0] RATIO_DEF = ssbf_pkg::RATIO_DEF;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on any port
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 24;    // extra wait after all bins and results have moved
  localparam int RANDOM_PHASE   = 65;    // bins per random phase
  localparam logic signed [DATA_W-1:0] DATA_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 24'sh800000;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } bin_word_t;

  typedef struct {
    logic [IDX_W-1:0] strongest;
    logic [IDX_W-1:0] significant;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_W-1:0] in_real_part = '0;
  logic signed [DATA_W-1:0] in_imag_part = '0;
  logic in_last_bin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_strongest_bin;
  logic [IDX_W-1:0] out_significant_bin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RATIO_W-1:0] cfg_ratio = '0;

  spectral_significant_bin_finder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_real_part        (in_real_part),
    .in_imag_part        (in_imag_part),
    .in_last_bin         (in_last_bin),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_strongest_bin   (out_strongest_bin),
    .out_significant_bin (out_significant_bin),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_ratio           (cfg_ratio)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bins waiting to be driven, and per-frame results still owed by the block
  bin_word_t     bin_queue[$];
  frame_result_t frame_result_q[$];

  int bins_pushed = 0;
  int bins_taken = 0;
  int frames_checked = 0;
  int ratio_writes = 0;
  int stalled_cycles = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  logic in_took = 1'b0;
  logic hold_armed = 1'b0;
  int hold_count = 0;

  // predictor state: the block's frame tracking as seen from outside
  logic [RATIO_W-1:0] ratio_now = RATIO_DEF;
  logic [MAG_W-1:0]   top_power = '0;
  logic [IDX_W-1:0]   top_bin = '0;
  logic [IDX_W-1:0]   signif_bin = '0;
  logic [IDX_W-1:0]   bin_pos = '0;

  function automatic void track_bin(logic signed [DATA_W-1:0] re,
                                    logic signed [DATA_W-1:0] im, logic last);
    logic [DATA_W-1:0]  abs_re;
    logic [DATA_W-1:0]  abs_im;
    logic [MAG_W-1:0]   power;
    logic [RATIO_W-1:0] r;
    logic [127:0]       scaled_power;
    logic [127:0]       scaled_top;
    frame_result_t      res;
    abs_re = re[DATA_W-1] ? DATA_W'(-re) : DATA_W'(re);
    abs_im = im[DATA_W-1] ? DATA_W'(-im) : DATA_W'(im);
    power = MAG_W'(abs_re) * MAG_W'(abs_re) + MAG_W'(abs_im) * MAG_W'(abs_im);
    r = (ratio_now == '0) ? RATIO_DEF : ratio_now;
    if (power > top_power) begin
      top_power = power;
      top_bin = bin_pos;
    end
    // amplitude test without sqrt: power * ratio^2 > peak * 2^16 (Q16.8 ratio)
    scaled_power = 128'(power) * 128'(r) * 128'(r);
    scaled_top = 128'(top_power) << 16;
    if (scaled_power > scaled_top) signif_bin = bin_pos;
    bin_pos = bin_pos + 1'b1;  // 12-bit index wraps with MAX_BINS = 4096
    if (last) begin
      res.strongest = top_bin;
      res.significant = signif_bin;
      frame_result_q.push_back(res);
      top_power = '0;
      top_bin = '0;
      signif_bin = '0;
      bin_pos = '0;
    end
  endfunction

  // monitor: sample at the rising edge, predict, check, watchdog
  always @(posedge clk) begin
    frame_result_t want;
    logic out_took;
    in_took = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        ratio_now = cfg_ratio;
        ratio_writes++;
      end
      if (in_valid && in_stall) stalled_cycles++;
      if (in_took) begin
        track_bin(in_real_part, in_imag_part, in_last_bin);
        bins_taken++;
      end
      if (out_took) begin
        if (frame_result_q.size() == 0) begin
          $error("result word with nothing expected: strongest_bin %0d significant_bin %0d",
                 out_strongest_bin, out_significant_bin);
          fail_count++;
        end else begin
          want = frame_result_q.pop_front();
          frames_checked++;
          if (out_strongest_bin !== want.strongest) begin
            $error("strongest_bin: expected %0d, actual %0d", want.strongest,
                   out_strongest_bin);
            fail_count++;
          end
          if (out_significant_bin !== want.significant) begin
            $error("significant_bin: expected %0d, actual %0d", want.significant,
                   out_significant_bin);
            fail_count++;
          end
        end
      end
      if (in_took || out_took || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    bin_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bin_queue.size() != 0) begin
        w = bin_queue.pop_front();
        in_real_part <= w.re;
        in_imag_part <= w.im;
        in_last_bin <= w.last;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            7:       gap_left = $urandom_range(10, 40);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall density changes every stretch; one long hold-off on request
  int stall_run = 0;
  int stall_pct = 0;

  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count++;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(4, 60);
        stall_pct = $urandom_range(0, 4) * 20;
      end else begin
        stall_run--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic bin_word_t make_bin(int unsigned scale, bin_word_t prev);
    bin_word_t   w;
    int unsigned pick;
    w.last = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.re = '0;
      w.im = '0;
    end else if (pick < 20) begin
      // same magnitude as the previous bin: swapped and/or negated parts
      if ($urandom_range(0, 1)) begin
        w.re = prev.im;
        w.im = prev.re;
      end else begin
        w.re = prev.re;
        w.im = prev.im;
      end
      if ($urandom_range(0, 1)) w.re = -w.re;
      if ($urandom_range(0, 1)) w.im = -w.im;
    end else if (pick < 25) begin
      w.re = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      w.im = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
    end else begin
      w.re = $signed(DATA_W'($urandom)) >>> scale;
      w.im = $signed(DATA_W'($urandom)) >>> (scale + $urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic push_bin(input bin_word_t w);
    bin_queue.push_back(w);
    bins_pushed++;
  endtask

  task automatic push_raw(input logic signed [DATA_W-1:0] re,
                          input logic signed [DATA_W-1:0] im, input logic last);
    bin_word_t w;
    w.re = re;
    w.im = im;
    w.last = last;
    push_bin(w);
  endtask

  // frames of random length; the last one may stay open across a ratio change
  task automatic queue_random_frames(input int n_bins, input bit leave_open);
    bin_word_t w;
    int left;
    int frame_len;
    int unsigned scale;
    int i;
    w = '{default: '0};
    left = n_bins;
    while (left > 0) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                              : $urandom_range(1, 12);
      if (frame_len > left) frame_len = left;
      scale = $urandom_range(0, 23);
      for (i = 0; i < frame_len; i++) begin
        w = make_bin(scale, w);
        w.last = (i == frame_len - 1) && !(leave_open && frame_len == left);
        push_bin(w);
      end
      left -= frame_len;
    end
  endtask

  task automatic drain();
    while (bins_taken != bins_pushed || frame_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_ratio <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [RATIO_W-1:0] ratio_plan [0:9];
    bin_word_t w;
    int i;
    ratio_plan = '{24'd0, RATIO_DEF, 24'd256, 24'd257, 24'd1, 24'hFFFFFF, 24'd512,
                   24'd1280, RATIO_W'($urandom), RATIO_W'($urandom_range(256, 6400))};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset ratio (100.0)
    push_raw(24'sd0, 24'sd0, 1'b0);       // all-zero frame
    push_raw(24'sd0, 24'sd0, 1'b1);
    push_raw(DATA_MAX, DATA_MIN, 1'b0);   // full-scale corners
    push_raw(DATA_MIN, DATA_MIN, 1'b0);   // largest power
    push_raw(DATA_MIN, DATA_MIN, 1'b0);   // tie with the peak: not a new peak
    push_raw(24'sd1, 24'sd0, 1'b0);
    push_raw(24'sd0, 24'sd1, 1'b1);
    push_raw(24'sd5, -24'sd3, 1'b1);      // single-bin frame
    push_raw(24'sd1000, 24'sd0, 1'b0);
    push_raw(24'sd100, 24'sd0, 1'b0);     // peak/10 amplitude: significant
    push_raw(24'sd10, 24'sd0, 1'b0);      // exactly at threshold: not significant
    push_raw(24'sd9, 24'sd0, 1'b1);
    push_raw(24'sd0, 24'sd0, 1'b0);
    push_raw(24'sd3, 24'sd4, 1'b0);
    push_raw(-24'sd4, -24'sd3, 1'b1);     // equal magnitude: both significant, later bin reported
    drain();

    for (i = 0; i < 10; i++) begin
      write_ratio(ratio_plan[i]);
      queue_random_frames(RANDOM_PHASE, (i % 2) == 0);
      drain();
    end

    // receiver holds off while one-bin frames keep coming: block backs up
    hold_armed = 1'b1;
    w = '{default: '0};
    for (i = 0; i < 40; i++) begin
      w = make_bin($urandom_range(0, 23), w);
      w.last = 1'b1;
      push_bin(w);
    end
    drain();

    $display("run covered %0d bins and %0d checked frames over %0d ratio writes;",
             bins_taken, frames_checked, ratio_writes);
    $display("input was held back for %0d cycles", stalled_cycles);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
design/ssbf_pkg.sv
design/ssbf_mul.sv
design/ssbf_ctrl.sv
design/spectral_significant_bin_finder.sv
test/tb_spectral_significant_bin_finder.sv
